FILE: sv/esms_pkg.sv
// Shared types, codes and next-state functions of the end-stop motor sequencer.
package esms_pkg;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [2:0] {
    REQ_FAST_TICK     = 3'd0,
    REQ_DIR           = 3'd1,
    REQ_HALL          = 3'd2,
    REQ_POWER_ON_HALL = 3'd3,
    REQ_SLOW_TICK     = 3'd4
  } req_kind_e;

  typedef enum logic [2:0] {
    CFG_PWM_ON      = 3'd0,
    CFG_PWM_PERIOD  = 3'd1,
    CFG_TICKS_MS    = 3'd2,
    CFG_TIMEOUT_MS  = 3'd3,
    CFG_RETRY_MS    = 3'd4,
    CFG_HALL_FAULT  = 3'd5
  } cfg_idx_e;

  localparam logic [1:0] DIR_NONE  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;

  localparam logic [1:0] POS_UNKNOWN = 2'd0;
  localparam logic [1:0] POS_RIGHT   = 2'd1;
  localparam logic [1:0] POS_LEFT    = 2'd2;
  localparam logic [1:0] POS_ERROR   = 2'd3;

  localparam logic [2:0] FAULT_HALL = 3'b100;

  typedef struct packed {
    logic [9:0]  pwm_on;
    logic [9:0]  pwm_period;
    logic [9:0]  ticks_per_ms;
    logic [15:0] timeout_ms;
    logic [15:0] retry_ms;
    logic [7:0]  hall_fault_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    pwm_on:           10'd80,
    pwm_period:       10'd100,
    ticks_per_ms:     10'd100,
    timeout_ms:       16'd1000,
    retry_ms:         16'd200,
    hall_fault_ticks: 8'd150
  };

  typedef struct packed {
    logic        pin_one;
    logic        pin_two;
    logic [1:0]  where_now;
    logic [1:0]  dir_now;
    logic [1:0]  dir_next;
    logic        running;
    logic        timing_out;
    logic        retry_pending;
    logic [9:0]  pulse_count;
    logic [9:0]  timeout_sub;
    logic [15:0] timeout_ms;
    logic [9:0]  retry_sub;
    logic [15:0] retry_ms;
    logic [7:0]  slow_count;
    logic        hall_fault;
    logic [2:0]  fault_bits;
  } st_t;

  localparam st_t ST_RESET = '{
    pin_one:       1'b1,
    pin_two:       1'b1,
    where_now:     POS_UNKNOWN,
    dir_now:       DIR_NONE,
    dir_next:      DIR_NONE,
    running:       1'b0,
    timing_out:    1'b0,
    retry_pending: 1'b0,
    pulse_count:   10'd0,
    timeout_sub:   10'd0,
    timeout_ms:    16'd0,
    retry_sub:     10'd0,
    retry_ms:      16'd0,
    slow_count:    8'd0,
    hall_fault:    1'b0,
    fault_bits:    3'd0
  };

  function automatic st_t brake_stop(st_t s);
    st_t r;
    begin
      r = s;
      r.running = 1'b0;
      r.dir_now = DIR_NONE;
      r.pin_one = 1'b1;
      r.pin_two = 1'b1;
      if (r.dir_next != DIR_NONE) begin
        r.retry_pending = 1'b1;
      end
      return r;
    end
  endfunction

  function automatic st_t request_dir(st_t s, logic [1:0] d);
    st_t r;
    begin
      r = s;
      if (d == DIR_RIGHT || d == DIR_LEFT) begin
        if (r.dir_now == DIR_NONE) begin
          if (r.where_now != d) begin
            r.dir_now     = d;
            r.timing_out  = 1'b1;
            r.running     = 1'b1;
            r.timeout_sub = '0;
            r.timeout_ms  = '0;
          end
        end else if (r.dir_next == DIR_NONE) begin
          r.dir_next = d;
        end
      end
      return r;
    end
  endfunction

  function automatic st_t fast_tick(st_t s, cfg_t c);
    st_t         r;
    logic [10:0] pn;
    logic [10:0] tsub;
    logic [16:0] tms;
    logic [10:0] rsub;
    logic [16:0] rms;
    begin
      r  = s;
      pn = {1'b0, r.pulse_count} + 11'd1;
      if (r.running) begin
        if (pn <= {1'b0, c.pwm_period}) begin
          r.pulse_count = pn[9:0];
          if (pn <= {1'b0, c.pwm_on}) begin
            if (r.dir_now == DIR_RIGHT) begin
              r.pin_one = 1'b1;
            end else if (r.dir_now == DIR_LEFT) begin
              r.pin_two = 1'b1;
            end
          end else begin
            r.pin_one = 1'b0;
            r.pin_two = 1'b0;
          end
        end else begin
          r.pulse_count = '0;
        end
      end
      tsub = {1'b0, r.timeout_sub} + 11'd1;
      tms  = {1'b0, r.timeout_ms} + 17'd1;
      if (r.timing_out) begin
        if (tsub >= {1'b0, c.ticks_per_ms}) begin
          r.timeout_sub = '0;
          if (tms >= {1'b0, c.timeout_ms}) begin
            r.timeout_ms = '0;
            r.timing_out = 1'b0;
            r.where_now  = POS_ERROR;
            r.fault_bits = r.fault_bits | {1'b0, r.dir_now};
            r = brake_stop(r);
          end else begin
            r.timeout_ms = tms[15:0];
          end
        end else begin
          r.timeout_sub = tsub[9:0];
        end
      end
      rsub = {1'b0, r.retry_sub} + 11'd1;
      rms  = {1'b0, r.retry_ms} + 17'd1;
      if (r.retry_pending) begin
        if (rsub >= {1'b0, c.ticks_per_ms}) begin
          r.retry_sub = '0;
          if (rms >= {1'b0, c.retry_ms}) begin
            r.retry_ms      = '0;
            r.retry_pending = 1'b0;
            r = request_dir(r, r.dir_next);
            r.dir_next = DIR_NONE;
          end else begin
            r.retry_ms = rms[15:0];
          end
        end else begin
          r.retry_sub = rsub[9:0];
        end
      end
      return r;
    end
  endfunction

  function automatic st_t hall_seen(st_t s, logic [1:0] side);
    st_t r;
    begin
      r = s;
      r.hall_fault = 1'b0;
      r.fault_bits = r.fault_bits & ~FAULT_HALL;
      r.where_now  = side;
      if (r.dir_now == side) begin
        r.timing_out = 1'b0;
        r.fault_bits = r.fault_bits & ~{1'b0, side};
        r = brake_stop(r);
      end
      return r;
    end
  endfunction

  function automatic st_t slow_tick(st_t s, cfg_t c);
    st_t        r;
    logic [8:0] sc;
    begin
      r  = s;
      sc = {1'b0, r.slow_count} + 9'd1;
      if (r.where_now == POS_ERROR) begin
        if (!r.hall_fault) begin
          if (sc >= {1'b0, c.hall_fault_ticks}) begin
            r.slow_count = '0;
            r.hall_fault = 1'b1;
            r.fault_bits = r.fault_bits | FAULT_HALL;
          end else begin
            r.slow_count = sc[7:0];
          end
        end
      end else begin
        r.slow_count = '0;
      end
      return r;
    end
  endfunction

endpackage

FILE: sv/endstop_motor_sequencer.sv
// Top level of the end-stop motor sequencer: event decode, state and result register.
//
// Events arrive on the slave stream: tuser carries the event kind (fast tick,
// direction request, hall sample, power-on hall sample, slow tick), tdata the
// requested direction and the two active-low hall readings. Every event gives
// exactly one result on the master stream: drive pin levels, position, moving
// and queued direction and the fault flags, all as they stand after the event.
// The result is registered and shows in the cycle after the input transfer.
// One event is taken every cycle unless the receiver stalls; the state update
// is done in the transfer cycle, so back-to-back events see each other at once.
// When the receiver stalls, the result register holds its transfer and the
// slave side takes one more event only when that result leaves in the same
// cycle. Reset brakes the motor (both pins high), clears position, moves and
// faults, and loads the default timing registers. The register port writes one
// timing register per cycle with no wait; write it while no event is in flight.
module endstop_motor_sequencer
  import esms_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // dir[1:0], hall_a_low[2], hall_b_low[3], zero[7:4]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // req_type[2:0]
  input  logic [InUserW-1:0]  s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // drive_ch1[0], drive_ch2[1], position[3:2], moving_dir[5:4], queued_dir[7:6],
  // fault_flags[10:8], zero[15:11]
  output logic [OutDataW-1:0] m_axis_tdata
);

  cfg_t                cfg_q;
  st_t                 state_q, state_d;
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic                in_xfer;
  logic [1:0]          req_dir;
  logic                hall_a, hall_b;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign req_dir       = s_axis_tdata[1:0];
  assign hall_a        = s_axis_tdata[2];
  assign hall_b        = s_axis_tdata[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PWM_ON:     cfg_q.pwm_on           <= cfg_data_i[9:0];
        CFG_PWM_PERIOD: cfg_q.pwm_period       <= cfg_data_i[9:0];
        CFG_TICKS_MS:   cfg_q.ticks_per_ms     <= cfg_data_i[9:0];
        CFG_TIMEOUT_MS: cfg_q.timeout_ms       <= cfg_data_i;
        CFG_RETRY_MS:   cfg_q.retry_ms         <= cfg_data_i;
        CFG_HALL_FAULT: cfg_q.hall_fault_ticks <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (req_kind_e'(s_axis_tuser))
      REQ_FAST_TICK: state_d = fast_tick(state_q, cfg_q);
      REQ_DIR:       state_d = request_dir(state_q, req_dir);
      REQ_HALL: begin
        if (hall_a) begin
          state_d = hall_seen(state_q, POS_RIGHT);
        end else if (hall_b) begin
          state_d = hall_seen(state_q, POS_LEFT);
        end else begin
          state_d.where_now = POS_ERROR;
        end
      end
      REQ_POWER_ON_HALL: begin
        state_d.where_now = hall_a ? POS_RIGHT : (hall_b ? POS_LEFT : POS_ERROR);
      end
      REQ_SLOW_TICK: state_d = slow_tick(state_q, cfg_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RESET;
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      state_q     <= state_d;
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q <= {5'd0, state_d.fault_bits, state_d.dir_next, state_d.dir_now,
                     state_d.where_now, state_d.pin_two, state_d.pin_one};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_run_has_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.running |-> state_q.dir_now != DIR_NONE)
    else $error("running without a direction");

  a_queue_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.dir_next != DIR_NONE |-> state_q.dir_now != DIR_NONE || state_q.retry_pending)
    else $error("queued direction with no move and no retry");

  a_hall_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.hall_fault == state_q.fault_bits[2])
    else $error("hall fault latch and flag disagree");

endmodule
